// ===== rtl/bhd_pkg.sv =====
// ----------------------------------------------------------------------------
// bhd_pkg
// Shared types and constants for the base64 / hex stream decoder.
// ----------------------------------------------------------------------------
package bhd_pkg;

    // Decode mode register values. The unused code acts as binary.
    localparam logic [1:0] MODE_BIN = 2'd0;
    localparam logic [1:0] MODE_HEX = 2'd1;
    localparam logic [1:0] MODE_B64 = 2'd2;

    // Error codes reported with the end marker.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_B64_CHAR = 3'd1;
    localparam logic [2:0] ERR_B64_PAD  = 3'd2;
    localparam logic [2:0] ERR_HEX_CHAR = 3'd3;
    localparam logic [2:0] ERR_HEX_ODD  = 3'd4;

    // Base64 pad character.
    localparam logic [7:0] CH_PAD = 8'h3D;

    // A classified character, passed from the front to the back.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       ws;
        logic       pad;
        logic       b64_ok;
        logic [5:0] b64_val;
        logic       hex_ok;
        logic [3:0] hex_val;
    } t_cls;

    // One result entry of the output queue.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic [2:0] err;
    } t_res;

endpackage

// ===== rtl/bhd_front.sv =====
// ----------------------------------------------------------------------------
// bhd_front
// Accepts characters, classifies them for hex and base64, and holds them in
// a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module bhd_front
    import bhd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output logic       o_avail,
    output t_cls       o_head,
    input  logic       i_take
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_cnt;
    t_cls          w_cls;
    logic          w_acc;
    logic          w_pop;
    logic [7:0]    w_diff;

    // Character classification, independent of the mode.
    always_comb begin
        w_cls         = '0;
        w_diff        = '0;
        w_cls.ch      = i_char;
        w_cls.last    = i_last;
        w_cls.ws      = (i_char == 8'h20) || ((i_char >= 8'h09) && (i_char <= 8'h0D));
        w_cls.pad     = (i_char == CH_PAD);

        // Base64 alphabet value.
        priority if ((i_char >= 8'h41) && (i_char <= 8'h5A)) begin
            w_diff        = i_char - 8'h41;
            w_cls.b64_ok  = 1'b1;
            w_cls.b64_val = w_diff[5:0];
        end else if ((i_char >= 8'h61) && (i_char <= 8'h7A)) begin
            w_diff        = i_char - 8'h61 + 8'd26;
            w_cls.b64_ok  = 1'b1;
            w_cls.b64_val = w_diff[5:0];
        end else if ((i_char >= 8'h30) && (i_char <= 8'h39)) begin
            w_diff        = i_char - 8'h30 + 8'd52;
            w_cls.b64_ok  = 1'b1;
            w_cls.b64_val = w_diff[5:0];
        end else if (i_char == 8'h2B) begin
            w_cls.b64_ok  = 1'b1;
            w_cls.b64_val = 6'd62;
        end else if (i_char == 8'h2F) begin
            w_cls.b64_ok  = 1'b1;
            w_cls.b64_val = 6'd63;
        end else begin
            w_cls.b64_ok  = 1'b0;
        end

        // Hex digit value.
        priority if ((i_char >= 8'h30) && (i_char <= 8'h39)) begin
            w_cls.hex_ok  = 1'b1;
            w_cls.hex_val = i_char[3:0];
        end else if (((i_char >= 8'h41) && (i_char <= 8'h46)) ||
                     ((i_char >= 8'h61) && (i_char <= 8'h66))) begin
            w_cls.hex_ok  = 1'b1;
            w_cls.hex_val = i_char[3:0] + 4'd9;
        end else begin
            w_cls.hex_ok  = 1'b0;
        end
    end

    // Queue control.
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign w_acc   = i_push && !o_full;
    assign w_pop   = i_take && o_avail;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_acc) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({w_acc, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_wr] <= w_cls;
        end
    end

endmodule

// ===== rtl/bhd_back.sv =====
// ----------------------------------------------------------------------------
// bhd_back
// Decodes classified characters in the selected mode and writes up to three
// results per character into the output queue.
// ----------------------------------------------------------------------------
module bhd_back
    import bhd_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_mode,
    input  logic       i_avail,
    input  t_cls       i_head,
    output logic       o_take,
    output logic       o_empty,
    input  logic       i_pop,
    output t_res       o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Decoder state.
    logic [1:0]  r_sc;
    logic [23:0] r_acc;
    logic        r_pad;
    logic [2:0]  r_err;
    logic [1:0]  n_sc;
    logic [23:0] n_acc;
    logic        n_pad;
    logic [2:0]  n_err;

    // Output queue.
    t_res          r_mem [DEPTH];
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_cnt;

    // Per-character results.
    logic [7:0]  w_byte [3];
    logic [1:0]  w_nb;
    logic [1:0]  w_nres;
    logic [2:0]  w_end_err;
    t_res        w_res  [3];
    logic [AW-1:0] w_idx [3];
    logic        w_flush;
    logic [2:0]  w_fcnt;
    logic [23:0] w_facc;
    logic [7:0]  w_acc8;
    logic [23:0] w_sh;
    logic        w_pop;
    logic [AW:0] w_sum;

    assign o_take  = i_avail && (r_cnt <= CW'(DEPTH - 3));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_head];
    assign w_pop   = i_pop && !o_empty;

    // Decode one character against the held group state.
    always_comb begin
        n_sc    = r_sc;
        n_acc   = r_acc;
        n_pad   = r_pad;
        n_err   = r_err;
        w_flush = 1'b0;
        w_fcnt  = '0;
        w_facc  = '0;
        w_acc8  = '0;
        w_sh    = '0;
        w_nb    = '0;
        w_byte[0] = '0;
        w_byte[1] = '0;
        w_byte[2] = '0;

        unique case (i_mode)
            MODE_HEX: begin
                if (!i_head.ws) begin
                    w_acc8 = r_acc[7:0];
                    if (!i_head.hex_ok) begin
                        n_err = ERR_HEX_CHAR;
                    end else begin
                        w_acc8 = {r_acc[3:0], i_head.hex_val};
                    end
                    if (r_sc != 2'd0) begin
                        w_byte[0] = w_acc8;
                        w_nb      = 2'd1;
                        n_sc      = 2'd0;
                        n_acc     = '0;
                    end else begin
                        n_sc  = 2'd1;
                        n_acc = {16'd0, w_acc8};
                    end
                end
                // An odd nibble at buffer end goes out alone.
                if (i_head.last && (n_sc != 2'd0)) begin
                    w_byte[0] = n_acc[7:0];
                    w_nb      = 2'd1;
                    n_err     = ERR_HEX_ODD;
                end
            end
            MODE_B64: begin
                if (r_pad) begin
                    if (!i_head.ws && !i_head.pad) begin
                        n_err = ERR_B64_PAD;
                    end
                end else if (!i_head.ws) begin
                    if (i_head.pad) begin
                        w_flush = 1'b1;
                        w_fcnt  = {1'b0, r_sc};
                        w_facc  = r_acc;
                        n_pad   = 1'b1;
                    end else if (!i_head.b64_ok) begin
                        n_err = ERR_B64_CHAR;
                    end else begin
                        unique case (r_sc)
                            2'd0:    w_sh = {i_head.b64_val, 18'd0};
                            2'd1:    w_sh = {6'd0, i_head.b64_val, 12'd0};
                            2'd2:    w_sh = {12'd0, i_head.b64_val, 6'd0};
                            default: w_sh = {18'd0, i_head.b64_val};
                        endcase
                        n_acc = r_acc | w_sh;
                        if (r_sc == 2'd3) begin
                            w_flush = 1'b1;
                            w_fcnt  = 3'd4;
                            w_facc  = n_acc;
                        end else begin
                            n_sc = r_sc + 2'd1;
                        end
                    end
                end
                // A partial group is flushed at buffer end.
                if (i_head.last && !n_pad && !w_flush) begin
                    w_flush = 1'b1;
                    w_fcnt  = {1'b0, n_sc};
                    w_facc  = n_acc;
                end
                if (w_flush) begin
                    n_sc  = 2'd0;
                    n_acc = '0;
                    w_byte[0] = w_facc[23:16];
                    w_byte[1] = w_facc[15:8];
                    w_byte[2] = w_facc[7:0];
                    priority if (w_fcnt == 3'd4) begin
                        w_nb = 2'd3;
                    end else if (w_fcnt == 3'd3) begin
                        w_nb = 2'd2;
                    end else if (w_fcnt != 3'd0) begin
                        w_nb = 2'd1;
                    end else begin
                        w_nb = 2'd0;
                    end
                end
            end
            default: begin
                w_byte[0] = i_head.ch;
                w_nb      = 2'd1;
            end
        endcase

        // The end marker rides on the last result, or on an empty one.
        w_end_err = n_err;
        w_nres    = (i_head.last && (w_nb == 2'd0)) ? 2'd1 : w_nb;
        for (int k = 0; k < 3; k++) begin
            w_res[k].valid = (2'(k) < w_nb);
            w_res[k].data  = w_res[k].valid ? w_byte[k] : 8'd0;
            w_res[k].last  = i_head.last && (2'(k) == w_nres - 2'd1);
            w_res[k].err   = w_res[k].last ? w_end_err : ERR_NONE;
        end
        if (i_head.last) begin
            n_sc  = '0;
            n_acc = '0;
            n_pad = 1'b0;
            n_err = ERR_NONE;
        end
    end

    // Write positions of the output queue.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum = {1'b0, r_tail} + (AW + 1)'(k);
            if (w_sum >= (AW + 1)'(DEPTH)) begin
                w_sum = w_sum - (AW + 1)'(DEPTH);
            end
            w_idx[k] = w_sum[AW-1:0];
        end
    end

    // Output queue pointers.
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        if (o_take) begin
            n_tail = (w_nres == 2'd0) ? r_tail : w_idx[w_nres - 2'd1];
            n_tail = (w_nres == 2'd0) ? n_tail :
                     ((n_tail == AW'(DEPTH - 1)) ? '0 : n_tail + 1'b1);
            n_cnt  = n_cnt + CW'(w_nres);
        end
        if (w_pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_cnt  = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc   <= '0;
            r_acc  <= '0;
            r_pad  <= 1'b0;
            r_err  <= ERR_NONE;
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
            if (o_take) begin
                r_sc  <= n_sc;
                r_acc <= n_acc;
                r_pad <= n_pad;
                r_err <= n_err;
            end
        end
    end

    // Output queue storage.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < w_nres) begin
                    r_mem[w_idx[k]] <= w_res[k];
                end
            end
        end
    end

endmodule

// ===== rtl/base64_hex_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_hex_stream_decoder
// Character stream decoder: binary passthrough, hex pairs or base64 groups.
// ----------------------------------------------------------------------------
// Path: a character accepted into the front queue is decoded when the back end
// takes it, and its results are written into the output queue.
// Throughput: one character per cycle while the output queue has room for three
// results; a completed base64 group adds three, which drain at one per cycle as popped.
// Reset: synchronous, active low; clears both queues, the group state and
// sets the mode to binary.
module base64_hex_stream_decoder
    import bhd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4,
    parameter int OUT_DEPTH   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_buffer_end,
    output logic [2:0] o_error_code,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    logic [1:0] r_mode;
    logic       w_avail;
    logic       w_take;
    t_cls       w_head;
    t_res       w_res;

    // Mode register; a configuration transaction is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BIN;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    bhd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_char  (i_in_char),
        .i_last  (i_in_last),
        .o_avail (w_avail),
        .o_head  (w_head),
        .i_take  (w_take)
    );

    bhd_back #(
        .DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_avail (w_avail),
        .i_head  (w_head),
        .o_take  (w_take),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (w_res)
    );

    assign o_out_byte   = w_res.data;
    assign o_byte_valid = w_res.valid;
    assign o_buffer_end = w_res.last;
    assign o_error_code = w_res.err;

endmodule

// ===== rtl/bhd_checker.sv =====
// ----------------------------------------------------------------------------
// bhd_checker
// Port-level assertions for the stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bhd_checker
    import bhd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_buffer_end,
    input logic [2:0] o_error_code
);

    // After reset the input queue is not full and the output queue is empty.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("queues not empty after reset");

    // A result without a byte is always the end marker.
    a_nobyte_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> o_buffer_end)
        else $error("empty result without end marker");

    // Errors are reported only with the end marker.
    a_err_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_buffer_end) |-> (o_error_code == ERR_NONE))
        else $error("error code outside end marker");

    // A result without a byte carries a zero byte.
    a_nobyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> (o_out_byte == 8'd0))
        else $error("nonzero byte on empty result");

    // A waiting result stays until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result lost");

endmodule

bind base64_hex_stream_decoder bhd_checker u_bhd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_out_byte   (o_out_byte),
    .o_byte_valid (o_byte_valid),
    .o_buffer_end (o_buffer_end),
    .o_error_code (o_error_code)
);

// ===== tb/sv/base64_hex_stream_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_hex_stream_decoder_checker
// Watches the character, result and mode channels of the decoder, predicts
// the decoded bytes of every accepted character and compares each popped
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module base64_hex_stream_decoder_checker
    import bhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_out_byte,
    input  logic       i_byte_valid,
    input  logic       i_buffer_end,
    input  logic [2:0] i_error_code,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results,
    output int         o_buffers_ended
);

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic [2:0] err;
    } t_byte_result;

    // Decoder state as the predictor sees it.
    logic [1:0]   decode_mode;
    logic [1:0]   group_cnt;
    logic [23:0]  group_bits;
    logic         pad_seen;
    logic [2:0]   buffer_err;

    t_byte_result decoded_q[$];
    t_byte_result char_out[3];
    int           char_out_n;
    int           mismatch_count = 0;
    int           result_count = 0;
    int           end_count = 0;

    function automatic bit is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Returns {ok, value} for a base64 symbol.
    function automatic logic [6:0] b64_lookup(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 26)};
        if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 52)};
        if (c == "+") return {1'b1, 6'd62};
        if (c == "/") return {1'b1, 6'd63};
        return 7'd0;
    endfunction

    // Returns {ok, value} for a hex digit.
    function automatic logic [4:0] hex_lookup(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
        return 5'd0;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        char_out[char_out_n] = '{data: b, valid: 1'b1, last: 1'b0, err: ERR_NONE};
        char_out_n++;
    endfunction

    // Emits the bytes of a base64 group holding cnt symbols.
    function automatic void flush_group(input int cnt);
        if (cnt >= 1) add_byte(group_bits[23:16]);
        if (cnt >= 3) add_byte(group_bits[15:8]);
        if (cnt == 4) add_byte(group_bits[7:0]);
        group_cnt  = 2'd0;
        group_bits = 24'd0;
    endfunction

    // Works out the results of one accepted character and queues them.
    function automatic void decode_char(input logic [7:0] c, input logic last);
        logic [6:0] sym;
        logic [4:0] nib;
        logic [7:0] pair;
        char_out_n = 0;
        case (decode_mode)
            MODE_HEX: begin
                if (!is_space(c)) begin
                    nib  = hex_lookup(c);
                    pair = group_bits[7:0];
                    // A bad digit still takes a nibble slot but adds no bits.
                    if (!nib[4]) buffer_err = ERR_HEX_CHAR;
                    else pair = {pair[3:0], nib[3:0]};
                    if (group_cnt != 2'd0) begin
                        add_byte(pair);
                        group_cnt  = 2'd0;
                        group_bits = 24'd0;
                    end else begin
                        group_cnt  = 2'd1;
                        group_bits = {16'd0, pair};
                    end
                end
                if (last && group_cnt != 2'd0) begin
                    add_byte(group_bits[7:0]);
                    buffer_err = ERR_HEX_ODD;
                end
            end
            MODE_B64: begin
                if (pad_seen) begin
                    if (!is_space(c) && c != CH_PAD) buffer_err = ERR_B64_PAD;
                end else if (!is_space(c)) begin
                    if (c == CH_PAD) begin
                        flush_group(group_cnt);
                        pad_seen = 1'b1;
                    end else begin
                        sym = b64_lookup(c);
                        if (!sym[6]) begin
                            buffer_err = ERR_B64_CHAR;
                        end else begin
                            group_bits = group_bits | (24'(sym[5:0]) << (6 * (3 - group_cnt)));
                            if (group_cnt == 2'd3) flush_group(4);
                            else group_cnt = group_cnt + 2'd1;
                        end
                    end
                end
                if (last && !pad_seen) flush_group(group_cnt);
            end
            default: begin
                add_byte(c);
            end
        endcase

        // The end marker rides on the last result, or on an empty one.
        if (last) begin
            if (char_out_n == 0) begin
                char_out[0] = '0;
                char_out_n  = 1;
            end
            char_out[char_out_n - 1].last = 1'b1;
            char_out[char_out_n - 1].err  = buffer_err;
            group_cnt  = 2'd0;
            group_bits = 24'd0;
            pad_seen   = 1'b0;
            buffer_err = ERR_NONE;
        end
        for (int k = 0; k < char_out_n; k++) decoded_q = {decoded_q, char_out[k]};
    endfunction

    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Results are checked before the character of the same edge is predicted,
    // since no result can come from a character accepted at that edge.
    always @(posedge i_clk) begin
        t_byte_result want;
        if (!i_rst_n) begin
            decode_mode = MODE_BIN;
            group_cnt   = 2'd0;
            group_bits  = 24'd0;
            pad_seen    = 1'b0;
            buffer_err  = ERR_NONE;
            decoded_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                result_count++;
                if (i_buffer_end) end_count++;
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %02h/%0b/%0b/%0d",
                             $time, i_out_byte, i_byte_valid, i_buffer_end, i_error_code);
                    mismatch_count++;
                end else begin
                    want = decoded_q.pop_front();
                    compare_field("out_byte", want.data, i_out_byte);
                    compare_field("byte_valid", want.valid, i_byte_valid);
                    compare_field("buffer_end", want.last, i_buffer_end);
                    compare_field("error_code", want.err, i_error_code);
                end
            end
            if (i_cfg_valid && i_cfg_ready) decode_mode = i_cfg_data;
            if (i_push && !i_full) decode_char(i_in_char, i_in_last);
        end
        o_fail_count    <= mismatch_count;
        o_pending       <= decoded_q.size();
        o_results       <= result_count;
        o_buffers_ended <= end_count;
    end

endmodule

// ===== tb/sv/base64_hex_stream_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_hex_stream_decoder_test
// Drives character buffers through the decoder in every mode setting: a
// directed opening over the corner cases, then random phases of mostly
// well-formed text with bursty input and a stalling output side. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module base64_hex_stream_decoder_test;
    import bhd_pkg::*;

    // The unused mode code behaves as binary.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 480;
    localparam int IDLE_WAIT    = 10;
    localparam int LONG_HOLD    = 80;
    localparam int CYCLE_LIMIT  = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] i_in_char = 8'd0;
    logic       i_in_last = 1'b0;
    logic       pop = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_data = 2'd0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_buffer_end;
    logic [2:0] o_error_code;
    logic       o_cfg_ready;

    int fail_count;
    int pending_count;
    int results_seen;
    int buffers_ended;

    int         items_sent = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b1;
    int         cycle_count = 0;
    int         input_stall_cycles = 0;
    int         hold_req = 0;
    int         hold_done = 0;
    int         hold_left = 0;
    int         pattern_slot = 0;
    logic [15:0] pop_pattern = '1;
    int         phase_count = 0;

    logic [1:0] phase_modes[8] = '{MODE_B64, MODE_HEX, MODE_B64, MODE_BIN,
                                   MODE_HEX, MODE_SPARE, MODE_B64, MODE_BIN};

    base64_hex_stream_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_char    (i_in_char),
        .i_in_last    (i_in_last),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_buffer_end (o_buffer_end),
        .o_error_code (o_error_code),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    base64_hex_stream_decoder_checker decode_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_in_char       (i_in_char),
        .i_in_last       (i_in_last),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_out_byte      (o_out_byte),
        .i_byte_valid    (o_byte_valid),
        .i_buffer_end    (o_buffer_end),
        .i_error_code    (o_error_code),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count),
        .o_results       (results_seen),
        .o_buffers_ended (buffers_ended)
    );

    always #1 i_clk = ~i_clk;

    // Cycle limit and input backpressure count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (push && full) input_stall_cycles <= input_stall_cycles + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: a 16-bit pop pattern, renewed after each full pass through its
    // bits, plus one long hold-off when the stimulus asks for it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_left <= LONG_HOLD;
            pop       <= 1'b0;
        end else begin
            pop          <= pop_pattern[pattern_slot];
            pattern_slot <= (pattern_slot + 1) % 16;
            if (pattern_slot == 15) begin
                case ($urandom_range(0, 3))
                    0: pop_pattern <= '1;
                    1: pop_pattern <= 16'($urandom);
                    2: pop_pattern <= 16'($urandom | $urandom);
                    default: pop_pattern <= 16'($urandom & $urandom);
                endcase
            end
        end
    end

    function automatic logic [7:0] space_char();
        int r;
        r = $urandom_range(0, 6);
        return (r == 6) ? 8'h20 : 8'(8'h09 + r);
    endfunction

    function automatic logic [7:0] b64_char(input int v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'("0" + v);
        return ($urandom_range(0, 1) != 0) ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    // Offers one character in bursts with random gaps; returns once it is taken.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0 && gaps_on) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        push      <= 1'b1;
        i_in_char <= c;
        i_in_last <= last;
        do @(posedge i_clk); while (full);
        items_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    task automatic send_chars(input logic [7:0] chars[$], input bit terminate);
        foreach (chars[k]) send_char(chars[k], terminate && k == chars.size() - 1);
    endtask

    task automatic write_mode(input logic [1:0] m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Stops the input and waits until every predicted result has been popped
    // and the block has had time to finish characters that emit nothing.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    // Base64 text: whole and partial groups, pads, stray whitespace and noise.
    task automatic send_b64_buffer(input bit terminate);
        logic [7:0] chars[$];
        int nsym;
        int r;
        nsym = $urandom_range(1, 14);
        for (int k = 0; k < nsym; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0) chars = {chars, space_char()};
            else if (r == 1) chars = {chars, 8'($urandom_range(0, 255))};
            chars = {chars, b64_char($urandom_range(0, 63))};
        end
        if (nsym % 4 != 0 && $urandom_range(0, 2) != 0) begin
            chars = {chars, CH_PAD};
            if (nsym % 4 != 3) chars = {chars, CH_PAD};
        end
        if ($urandom_range(0, 7) == 0) chars = {chars, b64_char($urandom_range(0, 63))};
        if ($urandom_range(0, 7) == 0) chars = {chars, space_char()};
        send_chars(chars, terminate);
    endtask

    // Hex text: digit pairs, sometimes an odd count, whitespace and bad digits.
    task automatic send_hex_buffer(input bit terminate);
        logic [7:0] chars[$];
        int n;
        int r;
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 15);
            if (r == 0) chars = {chars, space_char()};
            if (r == 1) chars = {chars, 8'($urandom_range(0, 255))};
            else chars = {chars, hex_char($urandom_range(0, 15))};
        end
        send_chars(chars, terminate);
    endtask

    task automatic send_raw_buffer(input bit terminate, input int n);
        logic [7:0] chars[$];
        for (int k = 0; k < n; k++) chars = {chars, 8'($urandom_range(0, 255))};
        send_chars(chars, terminate);
    endtask

    // A few buffers leave a phase open so state carries into the next mode.
    task automatic run_phase(input logic [1:0] m, input int target);
        int start;
        bit terminate;
        start = items_sent;
        while (items_sent - start < target) begin
            terminate = ($urandom_range(0, 11) != 0);
            case (m)
                MODE_HEX: send_hex_buffer(terminate);
                MODE_B64: send_b64_buffer(terminate);
                default: send_raw_buffer(terminate, $urandom_range(1, 8));
            endcase
        end
    endtask

    initial begin
        logic [1:0] m;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Binary after reset: lowest and highest character.
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        wait_idle();

        // Hex: bad digit, whitespace, a good pair, then an odd buffer.
        write_mode(MODE_HEX);
        send_char("4", 1'b0);
        send_char("g", 1'b0);
        send_char(" ", 1'b0);
        send_char("a", 1'b0);
        send_char("F", 1'b1);
        send_char("7", 1'b1);
        wait_idle();

        // Base64: pad flushing three symbols, data after the pad, a pad-only
        // end, an invalid symbol with a two-symbol tail, a full group.
        write_mode(MODE_B64);
        send_char("T", 1'b0);
        send_char("W", 1'b0);
        send_char("F", 1'b0);
        send_char(CH_PAD, 1'b0);
        send_char("A", 1'b0);
        send_char(8'h0A, 1'b0);
        send_char(CH_PAD, 1'b1);
        send_char("Q", 1'b0);
        send_char("*", 1'b0);
        send_char("B", 1'b1);
        send_char("T", 1'b0);
        send_char("W", 1'b0);
        send_char("F", 1'b0);
        send_char("u", 1'b1);
        send_char("Q", 1'b0);
        wait_idle();

        // Mode switched with one base64 symbol held, then the spare code.
        write_mode(MODE_HEX);
        send_char("5", 1'b1);
        wait_idle();
        write_mode(MODE_SPARE);
        send_char(8'h80, 1'b0);
        send_char(8'h41, 1'b1);
        wait_idle();

        // Random phases, one of them under a long result-side hold-off.
        for (int p = 0; items_sent < RANDOM_ITEMS; p++) begin
            m = phase_modes[p % 8];
            write_mode(m);
            if (p == 3) begin
                gaps_on = 1'b0;
                hold_req <= hold_req + 1;
                send_raw_buffer(1'b1, 40);
                gaps_on = 1'b1;
            end else begin
                run_phase(m, $urandom_range(25, 60));
            end
            wait_idle();
            phase_count++;
        end

        $display("Sent %0d characters in every mode code over %0d random phases.",
                 items_sent, phase_count);
        $display("Checked %0d results, %0d buffer ends; input stalled %0d cycles.",
                 results_seen, buffers_ended, input_stall_cycles);
        if (fail_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bhd_pkg.sv
rtl/bhd_front.sv
rtl/bhd_back.sv
rtl/base64_hex_stream_decoder.sv
rtl/bhd_checker.sv
tb/sv/base64_hex_stream_decoder_checker.sv
tb/sv/base64_hex_stream_decoder_test.sv
